### rtl/core/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Shared types, constants and arithmetic helpers for the Lorenz Euler stepper.
// ----------------------------------------------------------------------------
package les_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 24;
    localparam int GAIN_W   = 31;
    localparam int DT_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int OPND_W   = WORD_W + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int SUM_W    = 2 * WORD_W;
    localparam int ROOT_W   = WORD_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SEQ_LAST = 14;
    localparam int SQRT_LAST = ROOT_W;
    localparam int CNT_W    = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RHO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd6;

    localparam logic [GAIN_W-1:0] SIGMA_RST = 31'd167772160;
    localparam logic [GAIN_W-1:0] RHO_RST   = 31'd469762048;
    localparam logic [GAIN_W-1:0] BETA_RST  = 31'd44739243;
    localparam logic [DT_W-1:0]   DT_RST    = 25'd167772;
    localparam logic [WORD_W-1:0] START_RST = 32'd16777216;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SX,
        OP_XR,
        OP_XY,
        OP_BZ,
        OP_DXT,
        OP_DYT,
        OP_DZT,
        OP_SQX,
        OP_SQY,
        OP_SQZ
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_SQRT,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t  op;
        logic load;
        logic sqrt_load;
        logic sqrt_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic  ov;
        word_t val;
    } sat_t;

    // multiply sequence: derivative, Euler update, derivative, squares
    function automatic op_t op_at(logic [CNT_W-1:0] idx);
        op_t o;
        case (idx)
            6'd0, 6'd7:  o = OP_SX;
            6'd1, 6'd8:  o = OP_XR;
            6'd2, 6'd9:  o = OP_XY;
            6'd3, 6'd10: o = OP_BZ;
            6'd4:        o = OP_DXT;
            6'd5:        o = OP_DYT;
            6'd6:        o = OP_DZT;
            6'd11:       o = OP_SQX;
            6'd12:       o = OP_SQY;
            6'd13:       o = OP_SQZ;
            default:     o = OP_NONE;
        endcase
        return o;
    endfunction

    function automatic sat_t clamp(logic signed [PROD_W-1:0] v);
        localparam logic signed [PROD_W-1:0] SMAX = (PROD_W'(1) <<< (WORD_W - 1)) - 1;
        localparam logic signed [PROD_W-1:0] SMIN = -SMAX - 1;
        sat_t r;
        if (v > SMAX)
        begin
            r.ov = 1'b1;
            r.val = word_t'(SMAX);
        end
        else if (v < SMIN)
        begin
            r.ov = 1'b1;
            r.val = word_t'(SMIN);
        end
        else
        begin
            r.ov = 1'b0;
            r.val = word_t'(v);
        end
        return r;
    endfunction

    // fixed-point rescale of a full product, truncating toward zero
    function automatic sat_t mulq(logic signed [PROD_W-1:0] p);
        localparam logic signed [PROD_W-1:0] RND = (PROD_W'(1) <<< FRAC_W) - 1;
        logic signed [PROD_W-1:0] adj;
        adj = p + (p[PROD_W-1] ? RND : '0);
        return clamp(adj >>> FRAC_W);
    endfunction

    function automatic sat_t sat_add(word_t a, word_t b);
        return clamp(PROD_W'(a) + PROD_W'(b));
    endfunction

    function automatic sat_t sat_sub(word_t a, word_t b);
        return clamp(PROD_W'(a) - PROD_W'(b));
    endfunction

endpackage

### rtl/core/les_if.sv
// ----------------------------------------------------------------------------
// les_in_if / les_out_if
// Valid/ready channels for step requests and step results.
// ----------------------------------------------------------------------------
interface les_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface les_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] step_index;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [31:0] new_z;
    logic [31:0] speed;
    logic        overflow;
    modport source (output valid, output step_index, output new_x, output new_y,
                    output new_z, output speed, output overflow, input ready);
    modport sink   (input valid, input step_index, input new_x, input new_y,
                    input new_z, input speed, input overflow, output ready);
endinterface

### rtl/core/lorenz_euler_step.sv
// A request runs the multiply schedule on one shared 33x33 multiplier, then the
// bit-serial square root, then the hand-off to the output register.
// A new request is taken only in idle, so one step runs at a time.
// The output register lets a new request start while a result waits.
// Reset (rst_n, async, active low): registers take defaults, point is (1,1,1),
// step count is zero, no result pending.
// ----------------------------------------------------------------------------
// lorenz_euler_step
// Forward Euler stepper for the Lorenz system in saturating Q8.24.
// ----------------------------------------------------------------------------
module lorenz_euler_step
    import les_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    les_in_if.sink               in_ch,
    les_out_if.source            out_ch
);

    cmd_t cmd;

    les_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    les_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .restart    (in_ch.restart),
        .cmd        (cmd),
        .step_index (out_ch.step_index),
        .new_x      (out_ch.new_x),
        .new_y      (out_ch.new_y),
        .new_z      (out_ch.new_z),
        .speed      (out_ch.speed),
        .overflow   (out_ch.overflow)
    );

endmodule

### rtl/core/les_ctrl.sv
// ----------------------------------------------------------------------------
// les_ctrl
// Sequencer: walks the multiply schedule, the square root and the hand-off.
// ----------------------------------------------------------------------------
module les_ctrl
    import les_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cnt_reg == CNT_W'(SEQ_LAST))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_LAST))
                    state_next = S_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_RUN:  cmd.op = op_at(cnt_reg);
            S_SQRT:
            begin
                cmd.sqrt_load = (cnt_reg == '0);
                cmd.sqrt_step = (cnt_reg != '0);
            end
            S_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/les_datapath.sv
// ----------------------------------------------------------------------------
// les_datapath
// Shared 33x33 multiplier, saturating write-back, bit-serial square root.
// ----------------------------------------------------------------------------
module les_datapath
    import les_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 restart,
    input  cmd_t                 cmd,
    output logic [WORD_W-1:0]    step_index,
    output logic [WORD_W-1:0]    new_x,
    output logic [WORD_W-1:0]    new_y,
    output logic [WORD_W-1:0]    new_z,
    output logic [WORD_W-1:0]    speed,
    output logic                 overflow
);

    logic [GAIN_W-1:0] sigma_reg, rho_reg, beta_reg;
    logic [DT_W-1:0]   dt_reg;
    word_t             sx_reg, sy_reg, sz_reg;
    word_t             px_reg, py_reg, pz_reg;
    logic [WORD_W-1:0] count_reg, index_reg;
    logic              ov_reg;
    op_t               wb_op_reg;

    word_t             dx_reg, dy_reg, dz_reg, tmp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [WORD_W-1:0] o_index_reg, o_x_reg, o_y_reg, o_z_reg, o_speed_reg;
    logic              o_ov_reg;

    logic signed [OPND_W-1:0] mul_a, mul_b;
    sat_t diff_yx, diff_rz, mq, wb_res;
    logic issue_ov;
    logic wb_ov;
    logic [REM_W+1:0] rem_t, trial;

    // configuration and stepping state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RST;
            rho_reg   <= RHO_RST;
            beta_reg  <= BETA_RST;
            dt_reg    <= DT_RST;
            sx_reg    <= START_RST;
            sy_reg    <= START_RST;
            sz_reg    <= START_RST;
            count_reg <= '0;
            wb_op_reg <= OP_NONE;
        end
        else
        begin
            wb_op_reg <= cmd.op;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIGMA:   sigma_reg <= cfg_data[GAIN_W-1:0];
                    REG_RHO:     rho_reg   <= cfg_data[GAIN_W-1:0];
                    REG_BETA:    beta_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DT:      dt_reg    <= cfg_data[DT_W-1:0];
                    REG_START_X: sx_reg    <= cfg_data;
                    REG_START_Y: sy_reg    <= cfg_data;
                    REG_START_Z: sz_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load && restart)
                count_reg <= '0;
            else if (cmd.publish)
                count_reg <= index_reg + 1'b1;
        end
    end

    assign diff_yx = sat_sub(py_reg, px_reg);
    assign diff_rz = clamp(PROD_W'($signed({1'b0, rho_reg})) - PROD_W'(pz_reg));

    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        issue_ov = 1'b0;
        case (cmd.op)
            OP_SX:
            begin
                mul_a    = $signed({2'b0, sigma_reg});
                mul_b    = OPND_W'(diff_yx.val);
                issue_ov = diff_yx.ov;
            end
            OP_XR:
            begin
                mul_a    = OPND_W'(px_reg);
                mul_b    = OPND_W'(diff_rz.val);
                issue_ov = diff_rz.ov;
            end
            OP_XY:
            begin
                mul_a = OPND_W'(px_reg);
                mul_b = OPND_W'(py_reg);
            end
            OP_BZ:
            begin
                mul_a = $signed({2'b0, beta_reg});
                mul_b = OPND_W'(pz_reg);
            end
            OP_DXT:
            begin
                mul_a = OPND_W'(dx_reg);
                mul_b = $signed({{(OPND_W-DT_W){1'b0}}, dt_reg});
            end
            OP_DYT:
            begin
                mul_a = OPND_W'(dy_reg);
                mul_b = $signed({{(OPND_W-DT_W){1'b0}}, dt_reg});
            end
            OP_DZT:
            begin
                mul_a = OPND_W'(dz_reg);
                mul_b = $signed({{(OPND_W-DT_W){1'b0}}, dt_reg});
            end
            OP_SQX:
            begin
                mul_a = OPND_W'(dx_reg);
                mul_b = OPND_W'(dx_reg);
            end
            OP_SQY:
            begin
                mul_a = OPND_W'(dy_reg);
                mul_b = OPND_W'(dy_reg);
            end
            OP_SQZ:
            begin
                mul_a = OPND_W'(dz_reg);
                mul_b = OPND_W'(dz_reg);
            end
            default: ;
        endcase
    end

    assign mq = mulq(prod_reg);

    always_comb
    begin
        case (wb_op_reg)
            OP_XR:   wb_res = sat_sub(mq.val, py_reg);
            OP_BZ:   wb_res = sat_sub(tmp_reg, mq.val);
            OP_DXT:  wb_res = sat_add(px_reg, mq.val);
            OP_DYT:  wb_res = sat_add(py_reg, mq.val);
            OP_DZT:  wb_res = sat_add(pz_reg, mq.val);
            default: wb_res = mq;
        endcase
    end

    // squares are exact and never saturate
    assign wb_ov = (wb_op_reg inside {OP_SX, OP_XR, OP_XY, OP_BZ, OP_DXT, OP_DYT, OP_DZT})
                   && (wb_res.ov || mq.ov);

    // square-root trial: bring in two radicand bits per cycle
    assign rem_t = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial = {2'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= START_RST;
            py_reg <= START_RST;
            pz_reg <= START_RST;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ov_reg <= 1'b0;
                if (restart)
                begin
                    px_reg <= sx_reg;
                    py_reg <= sy_reg;
                    pz_reg <= sz_reg;
                end
            end
            else
            begin
                if (issue_ov || wb_ov)
                    ov_reg <= 1'b1;
                case (wb_op_reg)
                    OP_DXT:  px_reg <= wb_res.val;
                    OP_DYT:  py_reg <= wb_res.val;
                    OP_DZT:  pz_reg <= wb_res.val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
            index_reg <= restart ? '0 : count_reg;
        case (wb_op_reg)
            OP_SX:   dx_reg  <= wb_res.val;
            OP_XR:   dy_reg  <= wb_res.val;
            OP_XY:   tmp_reg <= wb_res.val;
            OP_BZ:   dz_reg  <= wb_res.val;
            OP_SQX:  sum_reg <= prod_reg[SUM_W-1:0];
            OP_SQY,
            OP_SQZ:  sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
            default: ;
        endcase
        if (cmd.sqrt_load)
        begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (rem_t >= trial)
            begin
                rem_reg  <= REM_W'(rem_t - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_t);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.publish)
        begin
            o_index_reg <= index_reg;
            o_x_reg     <= px_reg;
            o_y_reg     <= py_reg;
            o_z_reg     <= pz_reg;
            o_speed_reg <= root_reg;
            o_ov_reg    <= ov_reg;
        end
    end

    assign step_index = o_index_reg;
    assign new_x      = o_x_reg;
    assign new_y      = o_y_reg;
    assign new_z      = o_z_reg;
    assign speed      = o_speed_reg;
    assign overflow   = o_ov_reg;

endmodule

### rtl/core/les_checker.sv
// ----------------------------------------------------------------------------
// les_checker
// Port-level checks on the stepper's channels, bound to the top level.
// ----------------------------------------------------------------------------
module les_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] step_index,
    input logic [31:0] new_x
);

    // a started step keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while a step was running");

    // a fresh result is published only on the way back to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result published while busy");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(step_index) && $stable(new_x))
        else $error("result changed while stalled");

endmodule

bind lorenz_euler_step les_checker u_les_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .step_index (out_ch.step_index),
    .new_x      (out_ch.new_x)
);
